[rtl/core/ssrb_pkg.sv]
package ssrb_pkg;

  // Ring geometry
  localparam int unsigned DEPTH   = 32;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = PTR_W + 1;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned BYTE_W  = 8;

  // Stream widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_FIELDS_W = BYTE_W + 1 + 2 * LEVEL_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_SPI_XCHG = 2'd0,
    OP_HOST_PUT = 2'd1,
    OP_HOST_GET = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // Which ring supplies the result byte
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_TX,
    SRC_RX
  } src_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

[rtl/core/ssrb_ring.sv]
module ssrb_ring
  import ssrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              pop_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [CNT_W-1:0]  count_o,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] rdata_q;
  logic [SUM_W-1:0]  wr_sum;
  logic [PTR_W-1:0]  wr_idx;

  // Tail = head + count, folded back once into range
  assign wr_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign wr_idx = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                            : PTR_W'(wr_sum);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (push_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i) begin
      head_d  = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_idx] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem[head_q];
    end
  end

  assign count_o = count_q;
  assign rdata_o = rdata_q;

endmodule

[rtl/core/ssrb_datapath.sv]
module ssrb_datapath
  import ssrb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [BYTE_W-1:0]    data_in_i,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic                 accepted_o,
  output logic [LEVEL_W-1:0]   tx_level_o,
  output logic [LEVEL_W-1:0]   rx_level_o
);

  op_e               op_q;
  logic [BYTE_W-1:0] din_q;
  src_e              src_q, src_d;
  logic              acc_q, acc_d;

  logic              tx_push, tx_pop, rx_push, rx_pop;
  logic [CNT_W-1:0]  tx_count, rx_count;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;
  logic              tx_full, tx_empty, rx_full, rx_empty;

  assign tx_full  = (tx_count == CNT_W'(DEPTH));
  assign rx_full  = (rx_count == CNT_W'(DEPTH));
  assign tx_empty = (tx_count == '0);
  assign rx_empty = (rx_count == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      din_q <= data_in_i;
    end
  end

  // Decode one operation; rings move only in the execute cycle
  always_comb begin
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    src_d   = SRC_ZERO;
    acc_d   = 1'b0;
    case (op_q)
      OP_SPI_XCHG: begin
        rx_push = (din_q != '0) && !rx_full;
        tx_pop  = !tx_empty;
        acc_d   = rx_push;
        src_d   = tx_pop ? SRC_TX : SRC_ZERO;
      end
      OP_HOST_PUT: begin
        tx_push = !tx_full;
        acc_d   = tx_push;
      end
      OP_HOST_GET: begin
        rx_pop = !rx_empty;
        acc_d  = rx_pop;
        src_d  = rx_pop ? SRC_RX : SRC_ZERO;
      end
      OP_NONE: begin
        acc_d = 1'b0;
      end
      default: begin
        acc_d = 1'b0;
      end
    endcase
    if (!cmd_i.execute) begin
      tx_push = 1'b0;
      tx_pop  = 1'b0;
      rx_push = 1'b0;
      rx_pop  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= SRC_ZERO;
      acc_q <= 1'b0;
    end else if (cmd_i.execute) begin
      src_q <= src_d;
      acc_q <= acc_d;
    end
  end

  ssrb_ring u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tx_push),
    .pop_i   (tx_pop),
    .wdata_i (din_q),
    .count_o (tx_count),
    .rdata_o (tx_rdata)
  );

  ssrb_ring u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rx_push),
    .pop_i   (rx_pop),
    .wdata_i (din_q),
    .count_o (rx_count),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    case (src_q)
      SRC_TX:  out_byte_o = tx_rdata;
      SRC_RX:  out_byte_o = rx_rdata;
      default: out_byte_o = '0;
    endcase
  end

  assign accepted_o = acc_q;
  assign tx_level_o = LEVEL_W'(tx_count);
  assign rx_level_o = LEVEL_W'(rx_count);

endmodule

[rtl/core/ssrb_ctrl.sv]
module ssrb_ctrl
  import ssrb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/spi_slave_ring_buffers.sv]
// Sequencing: input taken in idle, rings updated in the execute state, result valid in respond.
// Throughput: no new transaction is taken until the previous result has been taken;
//   the controller sequence of capture, ring update and response sets this order.
// Reset: rst_ni is asynchronous, active low; it empties both rings (heads and counts
//   to zero) and returns the controller to idle. Ring storage itself is not cleared.
module spi_slave_ring_buffers
  import ssrb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_in
  input  logic [OP_W-1:0]      s_axis_tuser,  // [1:0] opcode
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // [7:0] out_byte, [8] accepted,
                                              // [14:9] tx_level, [20:15] rx_level
);

  dp_cmd_t             cmd;
  logic [BYTE_W-1:0]   out_byte;
  logic                accepted;
  logic [LEVEL_W-1:0]  tx_level;
  logic [LEVEL_W-1:0]  rx_level;

  // Sequence each transaction: take it in idle, update the rings, hold the result
  ssrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Both rings plus the operation decode; the result holds until the next execute
  ssrb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .opcode_i   (s_axis_tuser),
    .data_in_i  (s_axis_tdata[BYTE_W-1:0]),
    .out_byte_o (out_byte),
    .accepted_o (accepted),
    .tx_level_o (tx_level),
    .rx_level_o (rx_level)
  );

  // Pack result fields from the lowest bit up, pad with zeros to whole bytes
  assign m_axis_tdata = M_TDATA_W'({rx_level, tx_level, accepted, out_byte});

endmodule

[rtl/core/ssrb_checker.sv]
module ssrb_checker
  import ssrb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [OP_W-1:0]      s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One transaction in flight: no new input while a result is shown
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  // An accepted input is followed by a busy execute state, then by a shown result
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 m_axis_tvalid)
    else $error("result not presented two cycles after input");

  // Levels never exceed the ring depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:9] <= LEVEL_W'(DEPTH)) &&
                      (m_axis_tdata[20:15] <= LEVEL_W'(DEPTH)))
    else $error("ring level beyond depth");

  // An unused opcode never reports acceptance
  a_none_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_NONE)) |=> ##1
      !m_axis_tdata[8])
    else $error("unused opcode reported accepted");

endmodule

bind spi_slave_ring_buffers ssrb_checker u_ssrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/testbench.sv]
module testbench;
  import ssrb_pkg::*;

  // One input transaction: opcode on tuser, data_in on tdata
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  // One result, packed to match m_axis_tdata from the top bit down:
  // rx_level, tx_level, accepted, out_byte
  typedef struct packed {
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               accepted;
    logic [BYTE_W-1:0]  out_byte;
  } reply_t;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int CALM_START  = 1000;  // no random idling on either side in this window
  localparam int CALM_STOP   = 1800;
  localparam int HOLD_AT     = 400;   // receiver cycle at which the long hold-off starts
  localparam int HOLD_LEN    = 200;
  localparam int TAIL_CYCLES = 12;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [7:0] data_in
  logic [OP_W-1:0]      s_axis_tuser = '0;   // [1:0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // [7:0] out_byte, [8] accepted,
                                            // [14:9] tx_level, [20:15] rx_level

  item_t  pending_q[$];   // items still to be offered on the input stream
  reply_t reply_q[$];     // results owed by the block, oldest first
  int     fault_cnt = 0;
  int     cycle_cnt = 0;
  int     quiet_cnt = 0;
  int     hold_left = 0;
  int     rcv_cycles = 0;

  // Mirror of the two rings
  logic [7:0] tx_ring [DEPTH];
  logic [7:0] rx_ring [DEPTH];
  int         tx_rd = 0;
  int         tx_fill = 0;
  int         rx_rd = 0;
  int         rx_fill = 0;

  spi_slave_ring_buffers dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_item(op_e op, logic [7:0] data);
    item_t it;
    it.op   = op;
    it.data = data;
    pending_q.push_back(it);
  endfunction

  // Random idling, suppressed inside the calm window
  function automatic bit take_break();
    return (cycle_cnt < CALM_START || cycle_cnt >= CALM_STOP) && $urandom_range(0, 99) < 7;
  endfunction

  // Render the fields of one result for a report line
  function automatic string fmt_reply(reply_t r);
    return $sformatf("out_byte=%02h accepted=%0b tx_level=%0d rx_level=%0d",
                     r.out_byte, r.accepted, r.tx_level, r.rx_level);
  endfunction

  // Apply one transaction to the mirrored rings and return the result it owes
  function automatic reply_t ring_outcome(item_t it);
    reply_t r;
    r = '0;
    case (it.op)
      OP_SPI_XCHG: begin
        // Store the received byte unless it is zero or the receive ring is full
        if (it.data != 8'h00 && rx_fill < DEPTH) begin
          rx_ring[(rx_rd + rx_fill) % DEPTH] = it.data;
          rx_fill++;
          r.accepted = 1'b1;
        end
        // Load the next transmit byte for shift-out, zero when none waits
        if (tx_fill != 0) begin
          r.out_byte = tx_ring[tx_rd];
          tx_rd      = (tx_rd + 1) % DEPTH;
          tx_fill--;
        end
      end
      OP_HOST_PUT: begin
        if (tx_fill < DEPTH) begin
          tx_ring[(tx_rd + tx_fill) % DEPTH] = it.data;
          tx_fill++;
          r.accepted = 1'b1;
        end
      end
      OP_HOST_GET: begin
        if (rx_fill != 0) begin
          r.out_byte = rx_ring[rx_rd];
          rx_rd      = (rx_rd + 1) % DEPTH;
          rx_fill--;
          r.accepted = 1'b1;
        end
      end
      default: ;  // unused opcode: leave both rings alone
    endcase
    r.tx_level = LEVEL_W'(tx_fill);
    r.rx_level = LEVEL_W'(rx_fill);
    return r;
  endfunction

  // Driver: advance to the next pending item once the current one is taken,
  // hold the offer otherwise, and insert random bubbles between items.
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_q.size() != 0 && !take_break()) begin
        it = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= it.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and drops s_axis_tready while the driver keeps offering.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rcv_cycles <= rcv_cycles + 1;
      if (rcv_cycles == HOLD_AT) begin
        hold_left     <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !take_break();
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation,
  // then predict the result of any input transaction taken at this edge.
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    item_t  it;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = reply_t'(m_axis_tdata[M_FIELDS_W-1:0]);
        if (reply_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("unexpected result: %s", fmt_reply(got));
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            fault_cnt++;
            if (fault_cnt <= 10)
              $display("mismatch: expected %s, got %s", fmt_reply(want), fmt_reply(got));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.op   = op_e'(s_axis_tuser);
        it.data = s_axis_tdata;
        reply_q.push_back(ring_outcome(it));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either stream for too long
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt == STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    op_e        lead;
    op_e        op;
    logic [7:0] data;
    bit         mixed;
    int         len;

    // Directed: empty rings, zero filter, unused opcode, byte extremes, FIFO order
    add_item(OP_HOST_GET, 8'hFF);   // get from empty receive ring
    add_item(OP_SPI_XCHG, 8'h00);   // zero byte dropped, transmit ring empty
    add_item(OP_SPI_XCHG, 8'hFF);   // stored, shift-out gets zero
    add_item(OP_NONE,     8'hFF);   // no state change
    add_item(OP_HOST_PUT, 8'h00);
    add_item(OP_HOST_PUT, 8'hFF);
    add_item(OP_HOST_PUT, 8'h80);
    add_item(OP_SPI_XCHG, 8'h01);   // pops the zero byte the host put
    add_item(OP_SPI_XCHG, 8'h00);   // zero dropped while transmit pop still happens
    add_item(OP_HOST_GET, 8'h00);
    add_item(OP_HOST_GET, 8'h00);
    add_item(OP_HOST_GET, 8'h00);   // receive ring empty again
    add_item(OP_SPI_XCHG, 8'h7F);
    add_item(OP_SPI_XCHG, 8'h80);   // transmit ring drained, loads zero
    add_item(OP_NONE,     8'h00);
    add_item(OP_HOST_GET, 8'h55);
    add_item(OP_HOST_GET, 8'hAA);
    add_item(OP_HOST_PUT, 8'h55);
    add_item(OP_HOST_PUT, 8'hAA);
    add_item(OP_HOST_GET, 8'h00);
    add_item(OP_SPI_XCHG, 8'hC3);
    add_item(OP_SPI_XCHG, 8'h3C);

    // Walk both rings through full: fill transmit past depth, move it all
    // out while filling receive past depth, then drain receive past empty
    repeat (DEPTH + 4) add_item(OP_HOST_PUT, 8'($urandom_range(0, 255)));
    repeat (DEPTH + 4) add_item(OP_SPI_XCHG, 8'($urandom_range(1, 255)));
    repeat (DEPTH + 4) add_item(OP_HOST_GET, 8'($urandom_range(0, 255)));

    // Random bursts: each favors one opcode so the levels swing between the
    // extremes; some bursts are plain noise over all opcodes
    while (pending_q.size() < 830) begin
      lead  = op_e'(OP_W'($urandom_range(0, 2)));
      mixed = $urandom_range(0, 3) == 0;
      len   = $urandom_range(1, 45);
      repeat (len) begin
        if (mixed || $urandom_range(0, 99) >= 85)
          op = op_e'(OP_W'($urandom_range(0, 3)));
        else
          op = lead;
        if (op == OP_SPI_XCHG && $urandom_range(0, 9) != 0)
          data = 8'($urandom_range(1, 255));
        else
          data = 8'($urandom_range(0, 255));
        add_item(op, data);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to be taken and every result to come back
    @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fault_cnt == 0 && reply_q.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
